// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files (included by mexp_mulmod.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, held off while reset is asserted.
`define A_CHECK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define A_CHECK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
package mexp_pkg;

    // Field widths
    localparam int EXPONENT_BITS = 63;
    localparam int MODULUS_BITS  = 31;

    // Default modulus after reset: 10^9 + 7
    localparam logic [MODULUS_BITS-1:0] MODULUS_RESET = MODULUS_BITS'(1000000007);

    // Microcode step address
    typedef logic [3:0] t_step;

    // Datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,        // take an input beat when one is offered
        OP_ACC_ZERO,    // acc = 0
        OP_ACC_ONE,     // acc = 1
        OP_MM_BASE,     // start mulmod: base * (1 mod m), reduces the base
        OP_MM_STEP,     // one bit of the serial mulmod
        OP_TAKE_BASE,   // base = mulmod result, acc = 1 mod m
        OP_SKIP,        // drop a leading zero exponent bit
        OP_MM_SQ,       // start mulmod: acc * acc
        OP_MM_MUL,      // start mulmod: acc * base
        OP_TAKE_ACC,    // acc = mulmod result
        OP_SHIFT,       // advance to next exponent bit
        OP_EMIT         // load output register when it is free
    } t_op;

    // Jump condition of one step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_BASE_ZERO,
        C_EXP_ZERO,
        C_EXP_MSB_ZERO,
        C_MM_MORE,
        C_MORE_BITS,
        C_OUT_BUSY
    } t_cond;

    // Control word: operation, then jump to target if the condition holds
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic base_zero;
        logic exp_zero;
        logic exp_msb_zero;
        logic mm_more;
        logic more_bits;
        logic out_busy;
    } t_status;

    // Step addresses
    localparam t_step S_WAIT     = 4'd0;
    localparam t_step S_CHK_BASE = 4'd1;
    localparam t_step S_CHK_EXP  = 4'd2;
    localparam t_step S_RB_SET   = 4'd3;
    localparam t_step S_RB_RUN   = 4'd4;
    localparam t_step S_RB_END   = 4'd5;
    localparam t_step S_SKIP     = 4'd6;
    localparam t_step S_SQ_SET   = 4'd7;
    localparam t_step S_SQ_RUN   = 4'd8;
    localparam t_step S_SQ_END   = 4'd9;
    localparam t_step S_MU_SET   = 4'd10;
    localparam t_step S_MU_RUN   = 4'd11;
    localparam t_step S_MU_END   = 4'd12;
    localparam t_step S_NEXT     = 4'd13;
    localparam t_step S_EMIT     = 4'd14;
    localparam t_step S_DONE     = 4'd15;

    // Program ROM
    function automatic t_uword ucode_rom(input t_step step);
        t_uword uw;
        uw = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
        case (step)
            S_WAIT:     uw = '{op: OP_LOAD,      cond: C_NO_INPUT,     target: S_WAIT};
            S_CHK_BASE: uw = '{op: OP_ACC_ZERO,  cond: C_BASE_ZERO,    target: S_EMIT};
            S_CHK_EXP:  uw = '{op: OP_ACC_ONE,   cond: C_EXP_ZERO,     target: S_EMIT};
            S_RB_SET:   uw = '{op: OP_MM_BASE,   cond: C_NEVER,        target: S_WAIT};
            S_RB_RUN:   uw = '{op: OP_MM_STEP,   cond: C_MM_MORE,      target: S_RB_RUN};
            S_RB_END:   uw = '{op: OP_TAKE_BASE, cond: C_NEVER,        target: S_WAIT};
            S_SKIP:     uw = '{op: OP_SKIP,      cond: C_EXP_MSB_ZERO, target: S_SKIP};
            S_SQ_SET:   uw = '{op: OP_MM_SQ,     cond: C_NEVER,        target: S_WAIT};
            S_SQ_RUN:   uw = '{op: OP_MM_STEP,   cond: C_MM_MORE,      target: S_SQ_RUN};
            S_SQ_END:   uw = '{op: OP_TAKE_ACC,  cond: C_EXP_MSB_ZERO, target: S_NEXT};
            S_MU_SET:   uw = '{op: OP_MM_MUL,    cond: C_NEVER,        target: S_WAIT};
            S_MU_RUN:   uw = '{op: OP_MM_STEP,   cond: C_MM_MORE,      target: S_MU_RUN};
            S_MU_END:   uw = '{op: OP_TAKE_ACC,  cond: C_NEVER,        target: S_WAIT};
            S_NEXT:     uw = '{op: OP_SHIFT,     cond: C_MORE_BITS,    target: S_SQ_SET};
            S_EMIT:     uw = '{op: OP_EMIT,      cond: C_OUT_BUSY,     target: S_EMIT};
            S_DONE:     uw = '{op: OP_NOP,       cond: C_ALWAYS,       target: S_WAIT};
            default:    uw = '{op: OP_NOP,       cond: C_ALWAYS,       target: S_WAIT};
        endcase
        return uw;
    endfunction

endpackage

// ===== design/mexp_in_if.sv =====
interface mexp_in_if import mexp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODULUS_BITS-1:0]  base_value;
    logic [EXPONENT_BITS-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// ===== design/mexp_out_if.sv =====
interface mexp_out_if import mexp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODULUS_BITS-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

// ===== design/mexp_cfg_if.sv =====
interface mexp_cfg_if import mexp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODULUS_BITS-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

// ===== design/mexp_mulmod.sv =====
`include "assert_macros.svh"

// Serial modular multiplier: p = x * y mod m, one bit of x per step, MSB first.
// Requires y < m; p stays below m after every step.
module mexp_mulmod #(
    parameter int MODULUS_BITS = 31
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_step,
    input  logic [MODULUS_BITS-1:0] i_x,
    input  logic [MODULUS_BITS-1:0] i_y,
    input  logic [MODULUS_BITS-1:0] i_m,
    output logic [MODULUS_BITS-1:0] o_p,
    output logic                    o_more
);
    localparam int CW = $clog2(MODULUS_BITS + 1);
    localparam int TW = MODULUS_BITS + 2;

    logic [MODULUS_BITS-1:0] r_x, n_x;
    logic [MODULUS_BITS-1:0] r_y;
    logic [MODULUS_BITS-1:0] r_p, n_p;
    logic [CW-1:0]           r_cnt, n_cnt;

    logic [TW-1:0] dbl_sum;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;

    // 2p + bit*y, then fold back below m (sum is under 3m)
    always_comb begin
        m1      = {2'b00, i_m};
        m2      = {1'b0, i_m, 1'b0};
        dbl_sum = {1'b0, r_p, 1'b0} + (r_x[MODULUS_BITS-1] ? {2'b00, r_y} : '0);
        n_p     = r_p;
        n_x     = r_x;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_p   = '0;
            n_x   = i_x;
            n_cnt = CW'(MODULUS_BITS);
        end else if (i_step) begin
            if (dbl_sum >= m2) begin
                n_p = MODULUS_BITS'(dbl_sum - m2);
            end else if (dbl_sum >= m1) begin
                n_p = MODULUS_BITS'(dbl_sum - m1);
            end else begin
                n_p = MODULUS_BITS'(dbl_sum);
            end
            n_x   = {r_x[MODULUS_BITS-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
        end
    end

    // bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // operands and partial result
    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        r_x <= n_x;
        if (i_start) begin
            r_y <= i_y;
        end
    end

    assign o_p    = r_p;
    assign o_more = (r_cnt > CW'(1));

    `A_CHECK(a_p_below_m, i_clk, i_rst_n, (r_cnt != '0) |-> (r_p < i_m), "mulmod partial not reduced")
    `A_CHECK(a_start_idle, i_clk, i_rst_n, i_start |-> (r_cnt == '0), "mulmod restarted while running")
    `A_CHECK(a_step_running, i_clk, i_rst_n, i_step |-> (r_cnt != '0), "mulmod stepped while idle")

endmodule

// ===== design/mexp_seq.sv =====
// Microcode sequencer: step counter, program ROM, conditional jump.
module mexp_seq import mexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_uword
);
    t_step  r_step, n_step;
    t_uword uw;
    logic   jump;

    // fetch and branch
    always_comb begin
        uw = ucode_rom(r_step);
        case (uw.cond)
            C_NEVER:        jump = 1'b0;
            C_ALWAYS:       jump = 1'b1;
            C_NO_INPUT:     jump = !i_status.in_valid;
            C_BASE_ZERO:    jump = i_status.base_zero;
            C_EXP_ZERO:     jump = i_status.exp_zero;
            C_EXP_MSB_ZERO: jump = i_status.exp_msb_zero;
            C_MM_MORE:      jump = i_status.mm_more;
            C_MORE_BITS:    jump = i_status.more_bits;
            C_OUT_BUSY:     jump = i_status.out_busy;
            default:        jump = 1'b0;
        endcase
        n_step = jump ? uw.target : r_step + t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;

endmodule

// ===== design/mexp_dp.sv =====
// Datapath: modulus register, operand and accumulator registers,
// exponent shifter, output register. Driven by the control word.
module mexp_dp import mexp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_uword                   i_uword,
    output t_status                  o_status,
    input  logic                     i_in_valid,
    input  logic [MODULUS_BITS-1:0]  i_base_value,
    input  logic [EXPONENT_BITS-1:0] i_exponent,
    output logic                     o_in_ready,
    input  logic                     i_cfg_valid,
    input  logic [MODULUS_BITS-1:0]  i_cfg_modulus,
    output logic                     o_cfg_ready,
    output logic                     o_out_valid,
    output logic [MODULUS_BITS-1:0]  o_power_result,
    input  logic                     i_out_ready
);
    localparam int                      ECW     = $clog2(EXPONENT_BITS + 1);
    localparam logic [MODULUS_BITS-1:0] MOD_RST = MODULUS_RESET;

    logic [MODULUS_BITS-1:0]  r_mod;
    logic [MODULUS_BITS-1:0]  r_m;
    logic                     r_one;
    logic [MODULUS_BITS-1:0]  r_base, n_base;
    logic [MODULUS_BITS-1:0]  r_acc, n_acc;
    logic [EXPONENT_BITS-1:0] r_exp, n_exp;
    logic [ECW-1:0]           r_ecnt, n_ecnt;
    logic                     r_out_valid;
    logic [MODULUS_BITS-1:0]  r_out_data;

    logic                     in_fire;
    logic                     out_busy;
    logic                     emit;
    logic                     mm_start;
    logic                     mm_more;
    logic [MODULUS_BITS-1:0]  mm_x;
    logic [MODULUS_BITS-1:0]  mm_y;
    logic [MODULUS_BITS-1:0]  mm_p;
    logic [MODULUS_BITS-1:0]  one_mod;

    assign in_fire  = (i_uword.op == OP_LOAD) && i_in_valid;
    assign out_busy = r_out_valid && !i_out_ready;
    assign emit     = (i_uword.op == OP_EMIT) && !out_busy;
    assign one_mod  = {{(MODULUS_BITS-1){1'b0}}, r_one};

    // mulmod operand select
    always_comb begin
        mm_start = 1'b0;
        mm_x     = r_acc;
        mm_y     = r_acc;
        case (i_uword.op)
            OP_MM_BASE: begin
                mm_start = 1'b1;
                mm_x     = r_base;
                mm_y     = one_mod;
            end
            OP_MM_SQ: begin
                mm_start = 1'b1;
            end
            OP_MM_MUL: begin
                mm_start = 1'b1;
                mm_y     = r_base;
            end
            default: begin
                mm_start = 1'b0;
            end
        endcase
    end

    mexp_mulmod #(
        .MODULUS_BITS (MODULUS_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_step  (i_uword.op == OP_MM_STEP),
        .i_x     (mm_x),
        .i_y     (mm_y),
        .i_m     (r_m),
        .o_p     (mm_p),
        .o_more  (mm_more)
    );

    // accumulator, base and exponent updates
    always_comb begin
        n_base = r_base;
        n_acc  = r_acc;
        n_exp  = r_exp;
        n_ecnt = r_ecnt;
        case (i_uword.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    n_base = i_base_value;
                    n_exp  = i_exponent;
                    n_ecnt = ECW'(EXPONENT_BITS);
                end
            end
            OP_ACC_ZERO:  n_acc = '0;
            OP_ACC_ONE:   n_acc = MODULUS_BITS'(1);
            OP_TAKE_BASE: begin
                n_base = mm_p;
                n_acc  = one_mod;
            end
            OP_TAKE_ACC:  n_acc = mm_p;
            OP_SKIP: begin
                if (!r_exp[EXPONENT_BITS-1]) begin
                    n_exp  = r_exp << 1;
                    n_ecnt = r_ecnt - ECW'(1);
                end
            end
            OP_SHIFT: begin
                n_exp  = r_exp << 1;
                n_ecnt = r_ecnt - ECW'(1);
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    // config register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod       <= MOD_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= i_cfg_modulus;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers; modulus 0 acts as 1
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_acc  <= n_acc;
        r_exp  <= n_exp;
        r_ecnt <= n_ecnt;
        if (in_fire) begin
            r_m   <= (r_mod == '0) ? MODULUS_BITS'(1) : r_mod;
            r_one <= (r_mod > MODULUS_BITS'(1));
        end
        if (emit) begin
            r_out_data <= r_acc;
        end
    end

    always_comb begin
        o_status.in_valid     = i_in_valid;
        o_status.base_zero    = (r_base == '0);
        o_status.exp_zero     = (r_exp == '0);
        o_status.exp_msb_zero = !r_exp[EXPONENT_BITS-1];
        o_status.mm_more      = mm_more;
        o_status.more_bits    = (r_ecnt != ECW'(1));
        o_status.out_busy     = out_busy;
    end

    assign o_in_ready     = (i_uword.op == OP_LOAD);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out_data;

endmodule

// ===== design/modular_exponentiation.sv =====
// Channel  | Dir | Beat payload                 | Notes
// ---------+-----+------------------------------+-------------------------------
// i_in     | in  | base_value, exponent         | ready only while waiting for work
// o_out    | out | power_result                 | one beat per input beat, registered
// i_cfg    | in  | modulus                      | always ready, write while idle
//
// Zero base and zero exponent beats skip the multiplies. Each modular
// multiply runs through one serial add-and-fold unit under control of
// a 16-step microprogram.
// Reset is synchronous, active low; the modulus returns to 1000000007.
// A stalled result sits in the output register while the next beat is
// accepted and processed; the program waits at its emit step only if the
// previous result is still held.
module modular_exponentiation import mexp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_in_if.sink     i_in,
    mexp_out_if.source  o_out,
    mexp_cfg_if.sink    i_cfg
);
    t_uword  uword;
    t_status status;

    mexp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_uword  (uword)
    );

    mexp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uword        (uword),
        .o_status       (status),
        .i_in_valid     (i_in.valid),
        .i_base_value   (i_in.base_value),
        .i_exponent     (i_in.exponent),
        .o_in_ready     (i_in.ready),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_modulus  (i_cfg.modulus),
        .o_cfg_ready    (i_cfg.ready),
        .o_out_valid    (o_out.valid),
        .o_power_result (o_out.power_result),
        .i_out_ready    (o_out.ready)
    );

endmodule

// ===== dv/tb.sv =====
module tb import mexp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // One job for the block: base and exponent
    typedef struct packed {
        logic [30:0] base_value;
        logic [62:0] exponent;
    } t_pow_job;

    // Expected power for an accepted job
    typedef struct {
        t_pow_job    job;
        logic [30:0] power;
    } t_power_expect;

    logic clk = 1'b0;
    logic rst_n;

    mexp_in_if  in_if ();
    mexp_out_if out_if ();
    mexp_cfg_if cfg_if ();

    modular_exponentiation dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Jobs waiting to be offered, powers waiting to come out
    t_pow_job      job_q[$];
    t_power_expect power_q[$];

    // Modulus as the block holds it, tracked from the config beats
    logic [30:0] live_modulus = MODULUS_RESET;

    bit          offering = 1'b0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned mismatch_count = 0;
    int unsigned jobs_taken = 0;
    int unsigned powers_checked = 0;
    int unsigned modulus_writes = 0;

    always #1 clk = ~clk;

    // Square-and-multiply over all exponent bits, MSB first
    function automatic logic [30:0] mod_power(input logic [30:0] b_in,
                                              input logic [62:0] e_in,
                                              input logic [30:0] m_in);
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        if (b_in == '0)
            return '0;
        if (e_in == '0)
            return 31'd1;
        // modulus 0 acts as modulus 1
        m = (m_in == '0) ? 64'd1 : {33'd0, m_in};
        b = {33'd0, b_in} % m;
        acc = 64'd1 % m;
        for (int i = 62; i >= 0; i--) begin
            acc = (acc * acc) % m;
            if (e_in[i])
                acc = (acc * b) % m;
        end
        return acc[30:0];
    endfunction

    // Random job; exponents are mostly short to keep the run fast
    function automatic t_pow_job make_job(input bit short_exp);
        t_pow_job    j;
        int unsigned len;
        logic [63:0] r;
        r = {$urandom, $urandom};
        len = $urandom_range(1, 16);
        case ($urandom_range(0, 9))
            0:       j.base_value = '0;
            1:       j.base_value = '1;
            2:       j.base_value = live_modulus;
            3:       j.base_value = 31'($urandom_range(1, 20));
            default: j.base_value = 31'($urandom);
        endcase
        case (short_exp ? 3 : $urandom_range(0, 19))
            0:       j.exponent = '0;
            1, 2:    j.exponent = r[62:0];
            default: begin
                j.exponent = r[62:0] & ((63'd1 << len) - 63'd1);
                j.exponent[len-1] = 1'b1;
            end
        endcase
        return j;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // Add a job at the tail of the pending list
    task automatic append_job(input t_pow_job j);
        job_q.insert(job_q.size(), j);
    endtask

    task automatic queue_job(input logic [30:0] b, input logic [62:0] e);
        t_pow_job j;
        j.base_value = b;
        j.exponent = e;
        append_job(j);
    endtask

    task automatic queue_random(input int unsigned count, input int unsigned short_count);
        for (int unsigned k = 0; k < count; k++)
            append_job(make_job(k < short_count));
    endtask

    // Wait until every job is in and every power is out
    task automatic wait_drained();
        while (job_q.size() != 0 || offering || power_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Modulus write, only with the block idle
    task automatic write_modulus(input logic [30:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.modulus <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Job driver: offers the next job at the falling edge
    always @(negedge clk) begin : job_driver
        t_pow_job job;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!offering) begin
            if (job_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                job = job_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.base_value <= job.base_value;
                in_if.exponent <= job.exponent;
                offering = 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus the long hold-off
    always @(negedge clk) begin
        out_if.ready <= rst_n && hold_left == 0 && $urandom_range(0, 99) >= recv_stall_pct;
    end

    // Hold-off countdown
    always @(posedge clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: tracks config, predicts on input beats, checks output beats
    always @(posedge clk) begin : beat_monitor
        t_power_expect want;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                live_modulus = cfg_if.modulus;
                modulus_writes++;
            end
            if (in_if.valid && in_if.ready) begin
                want.job = '{base_value: in_if.base_value, exponent: in_if.exponent};
                want.power = mod_power(in_if.base_value, in_if.exponent, live_modulus);
                power_q.insert(power_q.size(), want);
                offering = 1'b0;
                jobs_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                if (power_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d", out_if.power_result));
                end else begin
                    want = power_q.pop_front();
                    powers_checked++;
                    if (out_if.power_result !== want.power)
                        report_mismatch($sformatf(
                            "base %0d exp 0x%h mod %0d: got %0d, want %0d",
                            want.job.base_value, want.job.exponent, live_modulus,
                            out_if.power_result, want.power));
                end
            end
        end
    end

    // Stimulus sequence
    initial begin : stimulus
        in_if.valid = 1'b0;
        in_if.base_value = '0;
        in_if.exponent = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.modulus = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset modulus 10^9+7, no idling
        queue_job('0, '0);
        queue_job('0, '1);
        queue_job('1, '0);
        queue_job(31'd1, '0);
        queue_job(31'd1000000007, '0);
        queue_job(31'd1000000007, 63'd3);
        queue_job(31'd2, 63'd1);
        queue_job(31'd2, 63'd62);
        queue_job('1, '1);
        queue_job('1, 63'd1);
        queue_job(31'd1000000006, 63'd2);
        queue_job(31'd3, 63'h5555_5555_5555_5555);
        queue_job(31'd7, 63'h4000_0000_0000_0000);
        queue_job(31'd123456789, 63'h2AAA_AAAA_AAAA_AAAA);
        queue_job(31'd2, 63'd1000000006);

        // Modulus one
        write_modulus(31'd1);
        queue_job('0, '0);
        queue_job(31'd5, '0);
        queue_job(31'd5, 63'd7);
        queue_job('1, '1);

        // Modulus zero behaves as one
        write_modulus('0);
        queue_job('0, '0);
        queue_job(31'd9, '0);
        queue_job(31'd9, 63'd5);
        queue_job(31'd1, 63'd1);

        // Largest modulus, sender idling
        write_modulus('1);
        send_idle_pct = 56;
        queue_random(150, 0);

        // Smallest useful modulus, receiver stalling
        write_modulus(31'd2);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        queue_random(100, 0);

        // Random modulus, both idling; long output hold fills the block
        write_modulus(31'($urandom_range(3, 32'h7FFF_FFFF)));
        send_idle_pct = 12;
        recv_stall_pct = 12;
        hold_left = 5000;
        queue_random(150, 6);

        // Default value written back; sender pauses until all results are out
        write_modulus(MODULUS_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(75, 0);
        wait_drained();
        queue_random(75, 0);

        // Small random modulus, both idling
        write_modulus(31'($urandom_range(3, 1000)));
        send_idle_pct = 12;
        recv_stall_pct = 12;
        queue_random(80, 0);

        wait_drained();
        repeat (100) @(posedge clk);

        $display("Covered %0d jobs and %0d results over %0d modulus writes.",
                 jobs_taken, powers_checked, modulus_writes);
        $display("Moduli 0, 1, 2, max, reset and random; zero base and exponent, full-width");
        $display("exponents, idle/stall mixes, long output hold.");
        if (mismatch_count == 0 && power_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40_000_000;
        $display("Timeout: %0d results still expected", power_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
